FILE: sv/rffr_pkg.sv
// shared types and constants of the rational filter frequency response block
package rffr_pkg;

   // item operation codes
   typedef enum logic [1:0] {
      OP_LOAD_NUM = 2'd0,
      OP_LOAD_DEN = 2'd1,
      OP_EVAL     = 2'd2,
      OP_RESTART  = 2'd3
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_NUM_ORDER = 2'd0,
      CSR_DEN_ORDER = 2'd1,
      CSR_THRESHOLD = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_ROUND,
      ST_MUL_AA,
      ST_MUL_BB,
      ST_MUL_RE,
      ST_MUL_IM,
      ST_MUL_END,
      ST_CHECK,
      ST_DIV,
      ST_OUT
   } state_type;

   localparam int TAP_W  = 18;   // q5.12 coefficient
   localparam int TRIG_W = 16;   // cos/sin magnitude in units of 2^-15
   localparam int PROD_W = 35;   // tap times signed trig value
   localparam int ACC_W  = 40;   // q27 sums
   localparam int CMP_W  = 29;   // q16 components
   localparam int NUM_W  = 58;   // products and their sums
   localparam int DEN_W  = 57;   // squared magnitude and dividend magnitude
   localparam int RES_W  = 32;   // q15.16 result
   localparam int QB_W   = 31;   // quotient bits below the sign

   localparam logic signed [TAP_W-1:0] TAP_ONE = 18'sd4096;
   localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

   // trig series constants, q30
   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint PI_Q30  = 64'sd3373259426;
   localparam longint COS_DIV [1:7] = '{2 * ONE_Q30, 12 * ONE_Q30, 30 * ONE_Q30,
      56 * ONE_Q30, 90 * ONE_Q30, 132 * ONE_Q30, 182 * ONE_Q30};
   localparam longint SIN_DIV [1:7] = '{6 * ONE_Q30, 20 * ONE_Q30, 42 * ONE_Q30,
      72 * ONE_Q30, 110 * ONE_Q30, 156 * ONE_Q30, 210 * ONE_Q30};

endpackage

FILE: sv/rational_filter_frequency_response.sv
// rational filter frequency response: top level with tap memories, trig rom and sequencer
// throughput: one item at a time; loads and restarts finish in the idle state, an evaluation
//   sweeps both tap memories one tap per cycle, then runs a 31 step serial divider
// reset: bin counter, zero-over-zero flag and registers cleared, threshold set to 1;
//   tap memories hold no reset value
module rational_filter_frequency_response #(
   parameter int POINTS   = 256,
   parameter int MAX_TAPS = 32
) (
   input  logic                clock,
   input  logic                reset,
   // item input
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [5:0]          req_tap_index,
   input  logic signed [17:0]  req_tap_value,
   // result output
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_bin_index,
   output logic signed [31:0]  rsp_response_real,
   output logic signed [31:0]  rsp_response_imag,
   output logic                rsp_pole_hit,
   output logic                rsp_last,
   // register writes
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);

   localparam int ADDR_W = $clog2(MAX_TAPS + 1);
   localparam int BIN_W  = $clog2(POINTS);
   localparam int PH_W   = $clog2(2 * POINTS);
   localparam int HALF   = POINTS / 2;
   localparam int QA_W   = $clog2(HALF + 1);
   localparam longint TWO_POINTS = 2 * POINTS;

   // first quadrant cos/sin entry for angle pi*m/POINTS, q15 magnitudes
   function automatic logic [2*rffr_pkg::TRIG_W-1:0] rom_entry(input longint m);
      longint x;
      longint x2;
      longint tc;
      longint ts;
      logic [rffr_pkg::TRIG_W-1:0] cq;
      logic [rffr_pkg::TRIG_W-1:0] sq;
      x  = (rffr_pkg::PI_Q30 * m * 2 + longint'(POINTS)) / TWO_POINTS;
      x2 = (x * x + (64'sd1 <<< 29)) >>> 30;
      tc = rffr_pkg::ONE_Q30;
      ts = rffr_pkg::ONE_Q30;
      for (int n = 7; n >= 1; n--) begin
         tc = rffr_pkg::ONE_Q30 - (x2 * tc) / rffr_pkg::COS_DIV[n];
         ts = rffr_pkg::ONE_Q30 - (x2 * ts) / rffr_pkg::SIN_DIV[n];
      end
      if (ts < 0) ts = 0;
      ts = (x * ts) >>> 30;
      if (tc < 0) tc = 0;
      cq = rffr_pkg::TRIG_W'((tc + 64'sd16384) >>> 15);
      sq = rffr_pkg::TRIG_W'((ts + 64'sd16384) >>> 15);
      return {cq, sq};
   endfunction

   // q27 to q16, round half away from zero
   function automatic logic signed [rffr_pkg::CMP_W-1:0] q27_to_q16(
      input logic signed [rffr_pkg::ACC_W-1:0] v);
      logic [rffr_pkg::ACC_W-1:0] mag;
      logic [rffr_pkg::CMP_W-1:0] r;
      mag = v[rffr_pkg::ACC_W-1] ? rffr_pkg::ACC_W'(-v) : rffr_pkg::ACC_W'(v);
      r   = rffr_pkg::CMP_W'((mag + 40'd1024) >> 11);
      return v[rffr_pkg::ACC_W-1] ? -r : r;
   endfunction

   // control state
   rffr_pkg::state_type state_ff, state_in;
   logic [BIN_W-1:0]    next_bin_ff, next_bin_in;
   logic                pending_ff, pending_in;
   logic [BIN_W-1:0]    k_ff, k_in;
   logic [ADDR_W-1:0]   i_ff, i_in;
   logic                den_sel_ff, den_sel_in;
   logic [PH_W-1:0]     phase_ff, phase_in;
   logic                fill_ff, fill_in;
   logic                second_ff, second_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // result payload
   logic [7:0]                         rsp_bin_ff, rsp_bin_in;
   logic signed [rffr_pkg::RES_W-1:0]  rsp_re_ff, rsp_re_in;
   logic signed [rffr_pkg::RES_W-1:0]  rsp_im_ff, rsp_im_in;
   logic                               rsp_pole_ff, rsp_pole_in;
   logic                               rsp_last_ff, rsp_last_in;

   // registers
   logic [5:0]  num_order_ff;
   logic [5:0]  den_order_ff;
   logic [31:0] thr_ff;

   // tap memories and trig rom
   logic signed [rffr_pkg::TAP_W-1:0]  num_taps_ff [0:MAX_TAPS];
   logic signed [rffr_pkg::TAP_W-1:0]  den_taps_ff [0:MAX_TAPS];
   logic signed [rffr_pkg::TAP_W-1:0]  num_rd_ff;
   logic signed [rffr_pkg::TAP_W-1:0]  den_rd_ff;
   logic [2*rffr_pkg::TRIG_W-1:0]      rom_table [0:HALF];
   logic [2*rffr_pkg::TRIG_W-1:0]      rom_rd_ff;

   // tap pipeline
   logic                               s1_vld_ff, s1_den_ff, s1_one_ff, s1_nc_ff, s1_ns_ff;
   logic                               s2_vld_ff, s2_den_ff;
   logic signed [rffr_pkg::PROD_W-1:0] prod_c_ff, prod_s_ff;
   logic signed [rffr_pkg::ACC_W-1:0]  acc_br_ff, acc_bi_ff, acc_ar_ff, acc_ai_ff;

   // post-sum datapath
   logic signed [rffr_pkg::CMP_W-1:0]  br_ff, bi_ff, ar_ff, ai_ff;
   logic signed [rffr_pkg::NUM_W-1:0]  mul_a_ff, mul_b_ff;
   logic [rffr_pkg::DEN_W-1:0]         da_ff, db_ff;
   logic signed [rffr_pkg::NUM_W-1:0]  nre_ff, nim_ff;

   // combinational helpers
   logic                               accept;
   logic                               issue;
   logic                               acc_clr;
   logic                               div_start;
   logic                               div_done_re, div_done_im;
   logic signed [rffr_pkg::RES_W-1:0]  quot_re, quot_im;
   logic [ADDR_W-1:0]                  nb, na, lim;
   logic [PH_W:0]                      ph_sum, ph_ext, m1, m2;
   logic                               fold_c, fold_s;
   logic [QA_W-1:0]                    rom_addr;
   logic signed [rffr_pkg::TAP_W-1:0]  tap_sel;
   logic signed [rffr_pkg::TRIG_W:0]   cos_s, sin_s;
   logic signed [rffr_pkg::CMP_W-1:0]  op_a, op_b, op_c, op_d;
   logic signed [rffr_pkg::NUM_W-1:0]  mul_sum, mul_diff;
   logic                               da_zero, db_zero;
   logic                               tap_idx_ok;

   for (genvar g = 0; g <= HALF; g++) begin : g_rom
      assign rom_table[g] = rom_entry(longint'(g));
   end

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == rffr_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign issue      = (state_ff == rffr_pkg::ST_SUM);
   assign tap_idx_ok = 7'(req_tap_index) <= 7'(MAX_TAPS);

   // orders above the tap store size count as the full size
   assign nb  = ({1'b0, num_order_ff} > 7'(MAX_TAPS)) ? ADDR_W'(MAX_TAPS)
                                                      : ADDR_W'(num_order_ff);
   assign na  = ({1'b0, den_order_ff} > 7'(MAX_TAPS)) ? ADDR_W'(MAX_TAPS)
                                                      : ADDR_W'(den_order_ff);
   assign lim = den_sel_ff ? na : nb;

   // angle of the next tap: previous angle plus k, mod 2*POINTS
   always_comb begin
      ph_sum = {1'b0, phase_ff} + (PH_W+1)'(k_ff);
      if (ph_sum >= (PH_W+1)'(2 * POINTS)) begin
         ph_sum = ph_sum - (PH_W+1)'(2 * POINTS);
      end
   end

   // fold the angle into the first quadrant
   always_comb begin
      ph_ext = {1'b0, phase_ff};
      fold_c = 1'b0;
      fold_s = 1'b0;
      m1     = ph_ext;
      if (ph_ext >= (PH_W+1)'(POINTS)) begin
         m1     = ph_ext - (PH_W+1)'(POINTS);
         fold_c = 1'b1;
         fold_s = 1'b1;
      end
      m2 = m1;
      if ((m1 << 1) > (PH_W+1)'(POINTS)) begin
         m2     = (PH_W+1)'(POINTS) - m1;
         fold_c = ~fold_c;
      end
      rom_addr = QA_W'(m2);
   end

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_order_ff <= '0;
         den_order_ff <= '0;
         thr_ff       <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            rffr_pkg::CSR_NUM_ORDER: num_order_ff <= csr_data[5:0];
            rffr_pkg::CSR_DEN_ORDER: den_order_ff <= csr_data[5:0];
            rffr_pkg::CSR_THRESHOLD: thr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // tap memories: write on load items, one registered read per cycle
   always_ff @(posedge clock) begin
      if (accept && tap_idx_ok && req_operation == rffr_pkg::OP_LOAD_NUM) begin
         num_taps_ff[ADDR_W'(req_tap_index)] <= req_tap_value;
      end
      if (accept && tap_idx_ok && req_operation == rffr_pkg::OP_LOAD_DEN) begin
         den_taps_ff[ADDR_W'(req_tap_index)] <= req_tap_value;
      end
      num_rd_ff <= num_taps_ff[i_ff];
      den_rd_ff <= den_taps_ff[i_ff];
      rom_rd_ff <= rom_table[rom_addr];
   end

   // tap pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // leading denominator tap is fixed at one
   assign tap_sel = s1_den_ff ? (s1_one_ff ? rffr_pkg::TAP_ONE : den_rd_ff) : num_rd_ff;
   assign cos_s   = s1_nc_ff ? -$signed({1'b0, rom_rd_ff[2*rffr_pkg::TRIG_W-1:rffr_pkg::TRIG_W]})
                             :  $signed({1'b0, rom_rd_ff[2*rffr_pkg::TRIG_W-1:rffr_pkg::TRIG_W]});
   assign sin_s   = s1_ns_ff ? -$signed({1'b0, rom_rd_ff[rffr_pkg::TRIG_W-1:0]})
                             :  $signed({1'b0, rom_rd_ff[rffr_pkg::TRIG_W-1:0]});

   // multiply then accumulate, tagged numerator or denominator
   always_ff @(posedge clock) begin
      s1_den_ff <= den_sel_ff;
      s1_one_ff <= den_sel_ff && (i_ff == '0);
      s1_nc_ff  <= fold_c;
      s1_ns_ff  <= fold_s;
      s2_den_ff <= s1_den_ff;
      prod_c_ff <= tap_sel * cos_s;
      prod_s_ff <= tap_sel * sin_s;
      if (acc_clr) begin
         acc_br_ff <= '0;
         acc_bi_ff <= '0;
         acc_ar_ff <= '0;
         acc_ai_ff <= '0;
      end else if (s2_vld_ff) begin
         if (s2_den_ff) begin
            acc_ar_ff <= acc_ar_ff + rffr_pkg::ACC_W'(prod_c_ff);
            acc_ai_ff <= acc_ai_ff - rffr_pkg::ACC_W'(prod_s_ff);
         end else begin
            acc_br_ff <= acc_br_ff + rffr_pkg::ACC_W'(prod_c_ff);
            acc_bi_ff <= acc_bi_ff - rffr_pkg::ACC_W'(prod_s_ff);
         end
      end
   end

   // two shared multipliers walk through the squares and cross products
   always_comb begin
      op_a = ar_ff;
      op_b = ar_ff;
      op_c = ai_ff;
      op_d = ai_ff;
      case (state_ff)
         rffr_pkg::ST_MUL_BB: begin
            op_a = br_ff; op_b = br_ff; op_c = bi_ff; op_d = bi_ff;
         end
         rffr_pkg::ST_MUL_RE: begin
            op_a = br_ff; op_b = ar_ff; op_c = bi_ff; op_d = ai_ff;
         end
         rffr_pkg::ST_MUL_IM: begin
            op_a = bi_ff; op_b = ar_ff; op_c = br_ff; op_d = ai_ff;
         end
         default: ;
      endcase
   end

   assign mul_sum  = mul_a_ff + mul_b_ff;
   assign mul_diff = mul_a_ff - mul_b_ff;

   always_ff @(posedge clock) begin
      mul_a_ff <= op_a * op_b;
      mul_b_ff <= op_c * op_d;
      if (state_ff == rffr_pkg::ST_ROUND) begin
         br_ff <= q27_to_q16(acc_br_ff);
         bi_ff <= q27_to_q16(acc_bi_ff);
         ar_ff <= q27_to_q16(acc_ar_ff);
         ai_ff <= q27_to_q16(acc_ai_ff);
      end
      if (state_ff == rffr_pkg::ST_MUL_BB)  da_ff  <= rffr_pkg::DEN_W'(mul_sum);
      if (state_ff == rffr_pkg::ST_MUL_RE)  db_ff  <= rffr_pkg::DEN_W'(mul_sum);
      if (state_ff == rffr_pkg::ST_MUL_IM)  nre_ff <= mul_sum;
      if (state_ff == rffr_pkg::ST_MUL_END) nim_ff <= mul_diff;
   end

   assign da_zero = da_ff <= rffr_pkg::DEN_W'(thr_ff);
   assign db_zero = db_ff <= rffr_pkg::DEN_W'(thr_ff);

   rffr_div u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (nre_ff),
      .den   (da_ff),
      .done  (div_done_re),
      .quot  (quot_re)
   );

   rffr_div u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (nim_ff),
      .den   (da_ff),
      .done  (div_done_im),
      .quot  (quot_im)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      next_bin_in  = next_bin_ff;
      pending_in   = pending_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      den_sel_in   = den_sel_ff;
      phase_in     = phase_ff;
      fill_in      = fill_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_re_in    = rsp_re_ff;
      rsp_im_in    = rsp_im_ff;
      rsp_pole_in  = rsp_pole_ff;
      rsp_last_in  = rsp_last_ff;
      acc_clr      = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         rffr_pkg::ST_IDLE: begin
            if (accept && req_operation == rffr_pkg::OP_RESTART) begin
               next_bin_in = '0;
               pending_in  = 1'b0;
            end else if (accept && req_operation == rffr_pkg::OP_EVAL) begin
               k_in        = next_bin_ff;
               next_bin_in = (next_bin_ff == BIN_W'(POINTS - 1)) ? '0
                                                                 : next_bin_ff + 1'b1;
               i_in        = '0;
               den_sel_in  = 1'b0;
               phase_in    = '0;
               acc_clr     = 1'b1;
               state_in    = rffr_pkg::ST_SUM;
            end
         end
         rffr_pkg::ST_SUM: begin
            // tap zero first with angle zero, numerator then denominator
            if (i_ff == lim) begin
               if (den_sel_ff) begin
                  state_in = rffr_pkg::ST_DRAIN;
               end else begin
                  den_sel_in = 1'b1;
                  i_in       = '0;
                  phase_in   = '0;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               phase_in = PH_W'(ph_sum);
            end
         end
         rffr_pkg::ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff) state_in = rffr_pkg::ST_ROUND;
         end
         rffr_pkg::ST_ROUND:   state_in = rffr_pkg::ST_MUL_AA;
         rffr_pkg::ST_MUL_AA:  state_in = rffr_pkg::ST_MUL_BB;
         rffr_pkg::ST_MUL_BB:  state_in = rffr_pkg::ST_MUL_RE;
         rffr_pkg::ST_MUL_RE:  state_in = rffr_pkg::ST_MUL_IM;
         rffr_pkg::ST_MUL_IM:  state_in = rffr_pkg::ST_MUL_END;
         rffr_pkg::ST_MUL_END: state_in = rffr_pkg::ST_CHECK;
         rffr_pkg::ST_CHECK: begin
            if (da_zero && db_zero) begin
               // zero over zero: no result, the next bin fills this one
               pending_in = 1'b1;
               state_in   = rffr_pkg::ST_IDLE;
            end else if (da_zero) begin
               // pole: saturated peak
               pending_in   = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_bin_in   = 8'(k_ff);
               rsp_re_in    = rffr_pkg::RES_MAX;
               rsp_im_in    = '0;
               rsp_pole_in  = 1'b1;
               rsp_last_in  = 1'b1;
               second_in    = 1'b0;
               state_in     = rffr_pkg::ST_OUT;
            end else begin
               fill_in    = pending_ff && (k_ff != '0);
               pending_in = 1'b0;
               div_start  = 1'b1;
               state_in   = rffr_pkg::ST_DIV;
            end
         end
         rffr_pkg::ST_DIV: begin
            // both dividers run in lockstep
            if (div_done_re && div_done_im) begin
               rsp_valid_in = 1'b1;
               rsp_re_in    = quot_re;
               rsp_im_in    = quot_im;
               rsp_pole_in  = 1'b0;
               if (fill_ff) begin
                  rsp_bin_in  = 8'(k_ff - 1'b1);
                  rsp_last_in = 1'b0;
                  second_in   = 1'b1;
               end else begin
                  rsp_bin_in  = 8'(k_ff);
                  rsp_last_in = 1'b1;
                  second_in   = 1'b0;
               end
               state_in = rffr_pkg::ST_OUT;
            end
         end
         rffr_pkg::ST_OUT: begin
            if (rsp_valid_ff && rsp_ready) begin
               if (second_ff) begin
                  rsp_bin_in  = 8'(k_ff);
                  rsp_last_in = 1'b1;
                  second_in   = 1'b0;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = rffr_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = rffr_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rffr_pkg::ST_IDLE;
         next_bin_ff  <= '0;
         pending_ff   <= 1'b0;
         i_ff         <= '0;
         den_sel_ff   <= 1'b0;
         phase_ff     <= '0;
         fill_ff      <= 1'b0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_bin_ff  <= next_bin_in;
         pending_ff   <= pending_in;
         i_ff         <= i_in;
         den_sel_ff   <= den_sel_in;
         phase_ff     <= phase_in;
         fill_ff      <= fill_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      rsp_bin_ff  <= rsp_bin_in;
      rsp_re_ff   <= rsp_re_in;
      rsp_im_ff   <= rsp_im_in;
      rsp_pole_ff <= rsp_pole_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bin_index     = rsp_bin_ff;
   assign rsp_response_real = rsp_re_ff;
   assign rsp_response_imag = rsp_im_ff;
   assign rsp_pole_hit      = rsp_pole_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

FILE: sv/rffr_div.sv
// serial restoring divider: signed dividend over unsigned divisor, q16 saturating quotient
module rffr_div (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [rffr_pkg::NUM_W-1:0]      num,
   input  logic        [rffr_pkg::DEN_W-1:0]      den,
   output logic                                   done,
   output logic signed [rffr_pkg::RES_W-1:0]      quot
);

   logic                           busy_ff;
   logic                           done_ff;
   logic [4:0]                     cnt_ff;
   logic [rffr_pkg::DEN_W-1:0]     rem_ff;
   logic [rffr_pkg::DEN_W-1:0]     den_ff;
   logic [rffr_pkg::QB_W-1:0]      low_ff;
   logic [rffr_pkg::QB_W-1:0]      q_ff;
   logic                           neg_ff;
   logic                           sat_ff;

   logic [rffr_pkg::DEN_W-1:0]     mag;
   logic [rffr_pkg::DEN_W:0]       trial;
   logic                           ge;

   assign mag   = num[rffr_pkg::NUM_W-1] ? rffr_pkg::DEN_W'(-num)
                                         : rffr_pkg::DEN_W'(num);
   assign trial = {rem_ff, low_ff[rffr_pkg::QB_W-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(rffr_pkg::QB_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // integer part too large means the quotient cannot fit
         rem_ff <= mag >> 15;
         sat_ff <= (mag >> 15) >= den;
         low_ff <= {mag[14:0], 16'd0};
         den_ff <= den;
         neg_ff <= num[rffr_pkg::NUM_W-1];
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? rffr_pkg::DEN_W'(trial - {1'b0, den_ff}) : rffr_pkg::DEN_W'(trial);
         low_ff <= low_ff << 1;
         q_ff   <= {q_ff[rffr_pkg::QB_W-2:0], ge};
      end
   end

   assign done = done_ff;

   always_comb begin
      if (sat_ff) begin
         quot = neg_ff ? rffr_pkg::RES_MIN : rffr_pkg::RES_MAX;
      end else if (neg_ff) begin
         quot = rffr_pkg::RES_W'(-{1'b0, q_ff});
      end else begin
         quot = {1'b0, q_ff};
      end
   end

endmodule

FILE: sv/rffr_chk.sv
// port checker for the rational filter frequency response block
module rffr_chk (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [1:0]          req_operation,
   input logic [5:0]          req_tap_index,
   input logic signed [17:0]  req_tap_value,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [7:0]          rsp_bin_index,
   input logic signed [31:0]  rsp_response_real,
   input logic signed [31:0]  rsp_response_imag,
   input logic                rsp_pole_hit,
   input logic                rsp_last,
   input logic                csr_valid,
   input logic                csr_ready,
   input logic [1:0]          csr_index,
   input logic [31:0]         csr_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_bin_index)
         && $stable(rsp_response_real) && $stable(rsp_response_imag))
      else $error("result changed while stalled");

   // pole result is the saturated peak and ends its item
   a_pole_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pole_hit |-> rsp_response_real == 32'sh7FFF_FFFF
         && rsp_response_imag == 32'sd0 && rsp_last)
      else $error("bad pole result");

   // a fill result is followed at once by its own bin with the same value
   a_fill_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last && !rsp_pole_hit
         && rsp_bin_index == $past(rsp_bin_index) + 8'd1
         && $stable(rsp_response_real) && $stable(rsp_response_imag))
      else $error("bad fill pair");

   // no item taken while a result is pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while result pending");

endmodule

bind rational_filter_frequency_response rffr_chk u_rffr_chk (.*);

FILE: test/tb.sv
// testbench for the rational filter frequency response block
`timescale 1ns / 100ps

module tb;

   localparam int NPOINTS    = 256;
   localparam int NTAPS      = 32;
   localparam int SETTLE     = 150;        // a bit above the worst evaluate latency
   localparam int LIMIT      = 1500000;
   localparam int HOLD_LEN   = 3000;
   localparam int SEG_ITEMS  = 27;

   typedef struct {
      rffr_pkg::op_type op;
      logic [5:0]       idx;
      logic [17:0]      val;
   } filter_item_type;

   typedef struct {
      logic [7:0]       bin;
      logic [31:0]      re;
      logic [31:0]      im;
      logic             pole;
      logic             last;
   } response_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [1:0]         req_operation;
   logic [5:0]         req_tap_index;
   logic signed [17:0] req_tap_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [7:0]         rsp_bin_index;
   logic signed [31:0] rsp_response_real;
   logic signed [31:0] rsp_response_imag;
   logic               rsp_pole_hit;
   logic               rsp_last;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [31:0]        csr_data;

   rational_filter_frequency_response dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_tap_index     (req_tap_index),
      .req_tap_value     (req_tap_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_bin_index     (rsp_bin_index),
      .rsp_response_real (rsp_response_real),
      .rsp_response_imag (rsp_response_imag),
      .rsp_pole_hit      (rsp_pole_hit),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // items waiting to be offered, and the item currently on the bus
   filter_item_type  item_q[$];
   filter_item_type  offered;
   // responses the filter model says must still come out
   response_type     response_q[$];

   // mirror of the block's state
   longint        num_coef [0:NTAPS];
   longint        den_coef [0:NTAPS];
   logic [5:0]    num_order;
   logic [5:0]    den_order;
   logic [31:0]   zero_thresh;
   int            bin_ptr;
   bit            zero_pending;

   int            send_idle_pct;
   int            recv_idle_pct;
   bit            hold_request;
   int            hold_left;
   int            mismatches;
   int            cycles;

   // ---------------------------------------------------------------
   // filter model
   // ---------------------------------------------------------------

   // round a q30 value (clamped at zero) to q15, half up
   function automatic longint round_q15(longint v);
      if (v < 0) v = 0;
      return (v + 16384) >>> 15;
   endfunction

   // cos/sin table entry for angle pi*m/POINTS, folded to the first quadrant
   function automatic void trig_entry(input int unsigned m_in,
                                      output longint c, output longint s);
      bit                neg_c;
      bit                neg_s;
      longint unsigned   mm;
      longint unsigned   x;
      longint unsigned   x2;
      longint            tc;
      longint            ts;
      longint            dc;
      longint            ds;
      neg_c = 0;
      neg_s = 0;
      tc = rffr_pkg::ONE_Q30;
      ts = rffr_pkg::ONE_Q30;
      mm = m_in % (2 * NPOINTS);
      if (mm >= NPOINTS) begin
         mm = mm - NPOINTS;
         neg_c = ~neg_c;
         neg_s = ~neg_s;
      end
      if (2 * mm > NPOINTS) begin
         mm = NPOINTS - mm;
         neg_c = ~neg_c;
      end
      x  = (longint'(rffr_pkg::PI_Q30) * mm * 2 + NPOINTS) / (2 * NPOINTS);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      // taylor series in horner form, truncating divides
      for (int n = 7; n >= 1; n--) begin
         dc = longint'((2 * n - 1) * (2 * n)) * rffr_pkg::ONE_Q30;
         ds = longint'((2 * n) * (2 * n + 1)) * rffr_pkg::ONE_Q30;
         tc = rffr_pkg::ONE_Q30 - (longint'(x2) * tc) / dc;
         ts = rffr_pkg::ONE_Q30 - (longint'(x2) * ts) / ds;
      end
      if (ts < 0) ts = 0;
      ts = longint'((x * longint'(ts)) >> 30);
      c = neg_c ? -round_q15(tc) : round_q15(tc);
      s = neg_s ? -round_q15(ts) : round_q15(ts);
   endfunction

   // q27 to q16, half away from zero
   function automatic longint q27_to_q16(longint v);
      if (v >= 0) return (v + 1024) / 2048;
      return -((-v + 1024) / 2048);
   endfunction

   // q32 / q32 long division giving a saturated q16 quotient
   function automatic longint quotient_q16(longint num, longint unsigned den);
      bit              neg;
      longint unsigned mag;
      longint unsigned q;
      longint unsigned r;
      neg = num < 0;
      mag = neg ? longint'(-num) : num;
      q = mag / den;
      r = mag % den;
      if (q >= 32768) begin
         q = 64'd2147483648;
      end else begin
         for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q = q | 1;
            end
         end
      end
      if (neg) return -longint'(q);
      if (q > 64'd2147483647) q = 64'd2147483647;
      return longint'(q);
   endfunction

   function automatic void push_response(int bin, longint re, longint im,
                                         bit pole, bit last);
      response_type r;
      r.bin  = bin[7:0];
      r.re   = re[31:0];
      r.im   = im[31:0];
      r.pole = pole;
      r.last = last;
      response_q.push_back(r);
   endfunction

   // evaluate the next bin and queue what the block should emit
   function automatic void evaluate_bin();
      int              k;
      int              nb;
      int              na;
      longint          br;
      longint          bi;
      longint          ar;
      longint          ai;
      longint          c;
      longint          s;
      longint unsigned mag_a;
      longint unsigned mag_b;
      longint          re;
      longint          im;
      k = bin_ptr % NPOINTS;
      bin_ptr = (k + 1 >= NPOINTS) ? 0 : k + 1;
      nb = (num_order > NTAPS) ? NTAPS : num_order;
      na = (den_order > NTAPS) ? NTAPS : den_order;
      br = num_coef[0] * 32768;
      bi = 0;
      for (int i = 1; i <= nb; i++) begin
         trig_entry(k * i, c, s);
         br += num_coef[i] * c;
         bi -= num_coef[i] * s;
      end
      ar = 64'sd134217728;   // leading denominator tap, fixed at one
      ai = 0;
      for (int i = 1; i <= na; i++) begin
         trig_entry(k * i, c, s);
         ar += den_coef[i] * c;
         ai -= den_coef[i] * s;
      end
      br = q27_to_q16(br);
      bi = q27_to_q16(bi);
      ar = q27_to_q16(ar);
      ai = q27_to_q16(ai);
      mag_a = ar * ar + ai * ai;
      mag_b = br * br + bi * bi;
      if (mag_a <= {32'd0, zero_thresh}) begin
         if (mag_b <= {32'd0, zero_thresh}) begin
            zero_pending = 1;   // nothing out now, the next good bin fills in
            return;
         end
         zero_pending = 0;
         push_response(k, 64'sd2147483647, 0, 1, 1);
         return;
      end
      re = quotient_q16(br * ar + bi * ai, mag_a);
      im = quotient_q16(bi * ar - br * ai, mag_a);
      if (zero_pending && k > 0) push_response(k - 1, re, im, 0, 0);
      zero_pending = 0;
      push_response(k, re, im, 0, 1);
   endfunction

   function automatic void apply_item(filter_item_type it);
      case (it.op)
         rffr_pkg::OP_LOAD_NUM:
            if (it.idx <= NTAPS) num_coef[it.idx] = longint'($signed(it.val));
         rffr_pkg::OP_LOAD_DEN:
            if (it.idx <= NTAPS) den_coef[it.idx] = longint'($signed(it.val));
         rffr_pkg::OP_RESTART: begin
            bin_ptr = 0;
            zero_pending = 0;
         end
         default: evaluate_bin();
      endcase
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic void queue_item(rffr_pkg::op_type op, int idx, int val);
      filter_item_type it;
      it.op  = op;
      it.idx = idx[5:0];
      it.val = val[17:0];
      item_q.push_back(it);
   endfunction

   // coefficient with a spread of magnitudes, full 18 bit field now and then
   function automatic int random_coef();
      case ($urandom_range(3))
         0: return $urandom_range(0, 262143);
         1: return int'($urandom_range(0, 16384)) - 8192;
         2: return int'($urandom_range(0, 1024)) - 512;
         default: return 0;
      endcase
   endfunction

   function automatic int random_order();
      case ($urandom_range(9))
         0: return 0;
         1: return NTAPS;
         2: return 63;   // above the tap count, clamps to it
         default: return $urandom_range(0, NTAPS);
      endcase
   endfunction

   function automatic int random_index();
      if ($urandom_range(9) == 0) return $urandom_range(NTAPS + 1, 63);
      return $urandom_range(0, NTAPS);
   endfunction

   // mostly evaluations over freshly perturbed taps, some restarts
   function automatic void queue_segment(int n);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 25) queue_item(rffr_pkg::OP_LOAD_NUM, random_index(), random_coef());
         else if (r < 45) queue_item(rffr_pkg::OP_LOAD_DEN, random_index(), random_coef());
         else if (r < 95) queue_item(rffr_pkg::OP_EVAL, $urandom_range(63), $urandom);
         else queue_item(rffr_pkg::OP_RESTART, $urandom_range(63), $urandom);
      end
   endfunction

   task automatic csr_write(rffr_pkg::csr_type idx, logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rffr_pkg::CSR_NUM_ORDER: num_order = data[5:0];
         rffr_pkg::CSR_DEN_ORDER: den_order = data[5:0];
         default:                 zero_thresh = data;
      endcase
   endtask

   // wait until everything sent has been answered, plus time for a silent bin
   task automatic wait_quiet();
      while (item_q.size() != 0 || req_valid || response_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      while (response_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_config();
      int t;
      csr_write(rffr_pkg::CSR_NUM_ORDER, random_order());
      csr_write(rffr_pkg::CSR_DEN_ORDER, random_order());
      t = $urandom_range(5);
      case (t)
         0: csr_write(rffr_pkg::CSR_THRESHOLD, 32'd0);
         1: csr_write(rffr_pkg::CSR_THRESHOLD, 32'd1);
         2: csr_write(rffr_pkg::CSR_THRESHOLD, 32'hFFFF_FFFF);
         3: csr_write(rffr_pkg::CSR_THRESHOLD, $urandom);
         default: csr_write(rffr_pkg::CSR_THRESHOLD, $urandom_range(0, 2000000));
      endcase
   endtask

   // ---------------------------------------------------------------
   // clock, timeout
   // ---------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // item driver: pops the queue, holds valid until accepted
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) apply_item(offered);
         if (!req_valid || req_ready) begin
            if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered = item_q.pop_front();
               req_valid     <= 1'b1;
               req_operation <= offered.op;
               req_tap_index <= offered.idx;
               req_tap_value <= offered.val;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         hold_left <= HOLD_LEN;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------
   // response monitor: checks each accepted response against the model
   // ---------------------------------------------------------------

   always @(posedge clock) begin
      response_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (response_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: bin %0d re %h im %h pole %b last %b",
                           rsp_bin_index, rsp_response_real, rsp_response_imag,
                           rsp_pole_hit, rsp_last);
            end else begin
               want = response_q.pop_front();
               if (rsp_bin_index !== want.bin || rsp_response_real !== want.re ||
                   rsp_response_imag !== want.im || rsp_pole_hit !== want.pole ||
                   rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected bin %0d re %h im %h pole %b last %b,",
                               " got bin %0d re %h im %h pole %b last %b"},
                              want.bin, want.re, want.im, want.pole, want.last,
                              rsp_bin_index, rsp_response_real, rsp_response_imag,
                              rsp_pole_hit, rsp_last);
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      req_operation = rffr_pkg::OP_LOAD_NUM;
      req_tap_index = '0;
      req_tap_value = '0;
      csr_valid     = 1'b0;
      csr_index     = rffr_pkg::CSR_NUM_ORDER;
      csr_data      = '0;
      hold_request  = 0;
      hold_left     = 0;
      mismatches    = 0;
      cycles        = 0;
      send_idle_pct = 35;
      recv_idle_pct = 81;
      num_order     = 0;
      den_order     = 0;
      zero_thresh   = 1;
      bin_ptr       = 0;
      zero_pending  = 0;
      for (int i = 0; i <= NTAPS; i++) begin
         num_coef[i] = 0;
         den_coef[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fill both tap memories so no later order reaches an unwritten tap
      for (int i = 0; i <= NTAPS; i++) begin
         queue_item(rffr_pkg::OP_LOAD_NUM, i, random_coef());
         queue_item(rffr_pkg::OP_LOAD_DEN, i, random_coef());
      end
      wait_quiet();
      csr_write(rffr_pkg::CSR_NUM_ORDER, 1);
      csr_write(rffr_pkg::CSR_DEN_ORDER, 1);
      csr_write(rffr_pkg::CSR_THRESHOLD, 1);

      // directed: coefficient extremes, ignored loads, pole, zero over zero
      queue_item(rffr_pkg::OP_LOAD_NUM, 0, -131072);
      queue_item(rffr_pkg::OP_LOAD_NUM, 0, 131071);
      queue_item(rffr_pkg::OP_EVAL, 63, 0);
      queue_item(rffr_pkg::OP_LOAD_DEN, 0, 131071);      // leading tap stays one
      queue_item(rffr_pkg::OP_LOAD_NUM, 63, 4096);       // beyond the last tap, dropped
      queue_item(rffr_pkg::OP_LOAD_DEN, 33, -4096);
      queue_item(rffr_pkg::OP_LOAD_NUM, 1, -4096);
      queue_item(rffr_pkg::OP_LOAD_NUM, 0, 4096);
      queue_item(rffr_pkg::OP_LOAD_DEN, 1, -4096);       // zero of a and b at dc
      queue_item(rffr_pkg::OP_RESTART, 0, 0);
      queue_item(rffr_pkg::OP_EVAL, 0, 0);               // zero over zero, silent
      queue_item(rffr_pkg::OP_EVAL, 0, 0);               // fills bin 0 and gives bin 1
      queue_item(rffr_pkg::OP_EVAL, 0, 0);
      queue_item(rffr_pkg::OP_LOAD_NUM, 1, 0);
      queue_item(rffr_pkg::OP_RESTART, 0, 0);
      queue_item(rffr_pkg::OP_EVAL, 0, 0);               // pole at dc
      queue_item(rffr_pkg::OP_EVAL, 0, 0);
      queue_item(rffr_pkg::OP_RESTART, 0, 0);
      queue_item(rffr_pkg::OP_EVAL, 0, 0);               // pole at dc again
      queue_item(rffr_pkg::OP_RESTART, 0, 0);            // back to bin 0
      queue_item(rffr_pkg::OP_LOAD_DEN, 1, 131071);
      queue_item(rffr_pkg::OP_LOAD_NUM, 1, -131072);
      queue_item(rffr_pkg::OP_EVAL, 0, 0);
      queue_item(rffr_pkg::OP_EVAL, 0, 0);

      // random part in three idling modes
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin send_idle_pct = 35; recv_idle_pct = 81; end
            1: begin send_idle_pct = 81; recv_idle_pct = 35; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int seg = 0; seg < 5; seg++) begin
            wait_quiet();
            random_config();
            // receiver stalls for a long stretch while items keep coming
            if (mode == 2 && seg == 0) hold_request = 1;
            queue_segment(SEG_ITEMS);
         end
      end

      // full sweep: notch and pole together at the last bin, then wrap to bin 0
      wait_quiet();
      csr_write(rffr_pkg::CSR_NUM_ORDER, 1);
      csr_write(rffr_pkg::CSR_DEN_ORDER, 1);
      csr_write(rffr_pkg::CSR_THRESHOLD, 1200000);
      queue_item(rffr_pkg::OP_LOAD_NUM, 0, 4096);
      queue_item(rffr_pkg::OP_LOAD_NUM, 1, 4096);
      queue_item(rffr_pkg::OP_LOAD_DEN, 1, 4096);
      queue_item(rffr_pkg::OP_RESTART, 0, 0);
      for (int i = 0; i < NPOINTS + 3; i++)
         queue_item(rffr_pkg::OP_EVAL, $urandom_range(63), $urandom);

      wait_quiet();
      if (mismatches == 0 && response_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
